FILE: rtl/octree_leaf_binning_core_macros.svh
// Assertion helpers shared by the binning core modules.
`ifndef OCTREE_LEAF_BINNING_CORE_MACROS_SVH
`define OCTREE_LEAF_BINNING_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/olb_pkg.sv
package olb_pkg;

  // Octree depth and counter limits
  localparam int MAX_LEVELS   = 4;
  localparam int MAX_ELEMENTS = 1048576;
  localparam int LEAF_W       = 3 * MAX_LEVELS;
  localparam int NUM_LEAVES   = 1 << LEAF_W;
  localparam int CLR_W        = LEAF_W + 1;
  localparam int LVL_W        = 3;

  // Field widths
  localparam int OP_W         = 2;
  localparam int PT_W         = 32;
  localparam int COORD_W      = PT_W + MAX_LEVELS;
  localparam int LEAF_IDX_W   = 12;
  localparam int COUNT_W      = 21;
  localparam int TAG_W        = 20;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ELEMENTS);

  // Queue between classifier and counter
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_COUNT      = 2'd0;
  localparam logic [OP_W-1:0] OP_PLACE      = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE       = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 3'd6;

  typedef struct packed {
    logic signed [PT_W-1:0] min_x;
    logic signed [PT_W-1:0] max_x;
    logic signed [PT_W-1:0] min_y;
    logic signed [PT_W-1:0] max_y;
    logic signed [PT_W-1:0] min_z;
    logic signed [PT_W-1:0] max_z;
    logic [LVL_W-1:0]       levels;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LEAF_W-1:0] leaf;
    logic [TAG_W-1:0]  tag;
  } q_item_t;

  // Child octant code from the three strict compares
  function automatic logic [2:0] child_code(input logic gx, input logic gy, input logic gz);
    logic [2:0] code;
    case ({gx, gy, gz})
      3'b000:  code = 3'd0;
      3'b001:  code = 3'd7;
      3'b010:  code = 3'd3;
      3'b011:  code = 3'd4;
      3'b100:  code = 3'd1;
      3'b101:  code = 3'd6;
      3'b110:  code = 3'd2;
      default: code = 3'd5;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/octree_leaf_binning_core.sv
// Octree leaf binning core.
// Input stream s_*: one request per beat. s_tuser carries op (0 count, 1 place,
// 2 read and clear, 3 no operation). s_tdata carries the point and tags.
// Output stream m_*: one result per request, in request order.
// cfg_*: register writes, taken whenever cfg_we is high; write only while idle.
// Throughput: one request per cycle unless m_tready or the clear sweep stalls it; the
// counter memory has a read and a write port, and same-leaf back-to-back requests are bypassed.
// Path to m_tvalid: the accepting edge loads the first of four level stages
// (one per octree level), then the queue write, the counter read and the
// output register follow.
// Reset: registers return to a unit box and one level; the 4096 leaf counters
// are then cleared by a sweep during which s_tready stays low.
// Receiver stall: the output register holds the result, the counter stage
// stops, the 4-entry queue fills and then s_tready drops; nothing is lost.
module octree_leaf_binning_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] point_x, [63:32] point_y, [95:64] point_z,
  // [107:96] leaf_select, [127:108] element_tag
  input  logic [127:0]                      s_tdata,
  // [1:0] op
  input  logic [olb_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [11:0] leaf_index, [32:12] count_or_slot, [52:33] tag_out,
  // [53] saturated, [55:54] zero
  output logic [55:0]                       m_tdata,
  input  logic                              cfg_we,
  input  logic [olb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [olb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import olb_pkg::*;

  cfg_t               cfg;
  logic               busy;
  logic               fr_ready;
  logic               q_push;
  logic               q_not_full;
  q_item_t            q_in;
  logic               q_pop;
  logic               q_not_empty;
  q_item_t            q_out;
  logic [LEAF_W-1:0]  out_leaf;
  logic [COUNT_W-1:0] out_val;
  logic [TAG_W-1:0]   out_tag;
  logic               out_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_x  <= '0;
      cfg.max_x  <= 32'sd65536;
      cfg.min_y  <= '0;
      cfg.max_y  <= 32'sd65536;
      cfg.min_z  <= '0;
      cfg.max_z  <= 32'sd65536;
      cfg.levels <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_X:  cfg.min_x  <= cfg_data;
        CFG_MAX_X:  cfg.max_x  <= cfg_data;
        CFG_MIN_Y:  cfg.min_y  <= cfg_data;
        CFG_MAX_Y:  cfg.max_y  <= cfg_data;
        CFG_MIN_Z:  cfg.min_z  <= cfg_data;
        CFG_MAX_Z:  cfg.max_z  <= cfg_data;
        CFG_LEVELS: cfg.levels <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off requests while the counter memory is being cleared
  assign s_tready = fr_ready && !busy;

  olb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid && !busy),
    .in_ready       (fr_ready),
    .in_op          (s_tuser),
    .in_px          (s_tdata[31:0]),
    .in_py          (s_tdata[63:32]),
    .in_pz          (s_tdata[95:64]),
    .in_leaf_select (s_tdata[107:96]),
    .in_tag         (s_tdata[127:108]),
    .q_push         (q_push),
    .q_ready        (q_not_full),
    .q_item         (q_in)
  );

  olb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out)
  );

  olb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .busy      (busy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_leaf  (out_leaf),
    .out_val   (out_val),
    .out_tag   (out_tag),
    .out_sat   (out_sat)
  );

  assign m_tdata = {2'b00, out_sat, out_tag, out_val, LEAF_IDX_W'(out_leaf)};

endmodule

FILE: rtl/olb_ram.sv
module olb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/olb_front.sv
module olb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  olb_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [olb_pkg::OP_W-1:0]      in_op,
  input  logic [olb_pkg::PT_W-1:0]      in_px,
  input  logic [olb_pkg::PT_W-1:0]      in_py,
  input  logic [olb_pkg::PT_W-1:0]      in_pz,
  input  logic [olb_pkg::LEAF_IDX_W-1:0] in_leaf_select,
  input  logic [olb_pkg::TAG_W-1:0]     in_tag,
  output logic                          q_push,
  input  logic                          q_ready,
  output olb_pkg::q_item_t              q_item
);
  import olb_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic                      classify;
    logic [LEAF_W-1:0]         leaf;
    logic [TAG_W-1:0]          tag;
    logic [PT_W-1:0]           px;
    logic [PT_W-1:0]           py;
    logic [PT_W-1:0]           pz;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] hi_z;
  } stage_t;

  // One octree level: halve the box on each axis, pick the child
  function automatic stage_t descend(input stage_t s, input logic act);
    stage_t r;
    logic [COORD_W:0] sx, sy, sz;
    logic signed [COORD_W-1:0] mx, my, mz;
    logic gx, gy, gz;
    sx = {s.lo_x[COORD_W-1], s.lo_x} + {s.hi_x[COORD_W-1], s.hi_x};
    sy = {s.lo_y[COORD_W-1], s.lo_y} + {s.hi_y[COORD_W-1], s.hi_y};
    sz = {s.lo_z[COORD_W-1], s.lo_z} + {s.hi_z[COORD_W-1], s.hi_z};
    // sums are even at every level, so the shift is exact
    mx = $signed(sx[COORD_W:1]);
    my = $signed(sy[COORD_W:1]);
    mz = $signed(sz[COORD_W:1]);
    gx = $signed({s.px, {MAX_LEVELS{1'b0}}}) > mx;
    gy = $signed({s.py, {MAX_LEVELS{1'b0}}}) > my;
    gz = $signed({s.pz, {MAX_LEVELS{1'b0}}}) > mz;
    r = s;
    if (act) begin
      if (gx) r.lo_x = mx; else r.hi_x = mx;
      if (gy) r.lo_y = my; else r.hi_y = my;
      if (gz) r.lo_z = mz; else r.hi_z = mz;
      r.leaf = {s.leaf[LEAF_W-4:0], child_code(gx, gy, gz)};
    end
    return r;
  endfunction

  stage_t           head;
  stage_t           st_in [MAX_LEVELS];
  stage_t           st    [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] vld;
  logic [LVL_W-1:0] n_lvl;
  logic             en;

  assign n_lvl = (cfg.levels > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : cfg.levels;

  // whole pipe advances unless its last stage is blocked by a full queue
  assign en       = !vld[MAX_LEVELS-1] || q_ready;
  assign in_ready = en;

  // Widen the root box and the request into the stage format
  always_comb begin
    head.op       = in_op;
    head.classify = (in_op == OP_COUNT) || (in_op == OP_PLACE);
    head.leaf     = (in_op == OP_READ_CLEAR) ? in_leaf_select[LEAF_W-1:0] : '0;
    head.tag      = in_tag;
    head.px       = in_px;
    head.py       = in_py;
    head.pz       = in_pz;
    head.lo_x     = $signed({cfg.min_x, {MAX_LEVELS{1'b0}}});
    head.hi_x     = $signed({cfg.max_x, {MAX_LEVELS{1'b0}}});
    head.lo_y     = $signed({cfg.min_y, {MAX_LEVELS{1'b0}}});
    head.hi_y     = $signed({cfg.max_y, {MAX_LEVELS{1'b0}}});
    head.lo_z     = $signed({cfg.min_z, {MAX_LEVELS{1'b0}}});
    head.hi_z     = $signed({cfg.max_z, {MAX_LEVELS{1'b0}}});
  end

  // One registered stage per octree level
  for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_lvl
    if (l == 0) begin : g_first
      assign st_in[l] = head;
    end else begin : g_rest
      assign st_in[l] = st[l-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[l] <= 1'b0;
      end else if (en) begin
        vld[l] <= (l == 0) ? in_valid : vld[(l == 0) ? 0 : l-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[l] <= descend(st_in[l], st_in[l].classify && (LVL_W'(l) < n_lvl));
      end
    end
  end

  // Hand the classified request to the queue
  assign q_push      = vld[MAX_LEVELS-1] && q_ready;
  assign q_item.op   = st[MAX_LEVELS-1].op;
  assign q_item.leaf = st[MAX_LEVELS-1].leaf;
  assign q_item.tag  = st[MAX_LEVELS-1].tag;

endmodule

FILE: rtl/olb_fifo.sv
`include "octree_leaf_binning_core_macros.svh"

module olb_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  olb_pkg::q_item_t push_item,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output olb_pkg::q_item_t pop_item
);
  import olb_pkg::*;

  q_item_t         mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign not_full  = count != (Q_AW+1)'(Q_DEPTH);
  assign not_empty = count != '0;
  assign pop_item  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `OLB_ASSERT_IMPL(a_q_bound, clk, rst, 1'b1, count <= (Q_AW+1)'(Q_DEPTH), "queue overfilled")
  `OLB_ASSERT_NEXT(a_q_empty_pop, clk, rst, !not_empty && !push, !not_empty || count == '0, "queue level moved without push")

endmodule

FILE: rtl/olb_back.sv
`include "octree_leaf_binning_core_macros.svh"

module olb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  olb_pkg::q_item_t               q_item,
  output logic                           q_pop,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [olb_pkg::LEAF_W-1:0]     out_leaf,
  output logic [olb_pkg::COUNT_W-1:0]    out_val,
  output logic [olb_pkg::TAG_W-1:0]      out_tag,
  output logic                           out_sat
);
  import olb_pkg::*;

  logic [CLR_W-1:0]   clr_cnt;
  logic               clearing;
  logic               en;
  logic               b_valid;
  q_item_t            b_item;
  logic [COUNT_W-1:0] rd_data;
  logic               fwd_valid;
  logic [LEAF_W-1:0]  fwd_addr;
  logic [COUNT_W-1:0] fwd_data;
  logic [COUNT_W-1:0] cur;
  logic               full;
  logic               item_wr;
  logic [COUNT_W-1:0] new_cnt;
  logic [COUNT_W-1:0] res_val;
  logic               res_sat;
  logic               wr_en;
  logic [LEAF_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  // Clearing sweep over the counter memory after reset
  assign clearing = !clr_cnt[CLR_W-1];
  assign busy     = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Advance when the output register is free or being drained
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid && !clearing;

  // Counter read issued as the request leaves the queue
  olb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_LEAVES)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (q_pop),
    .rd_addr (q_item.leaf),
    .rd_data (rd_data)
  );

  // Current count, bypassing the write made on the same edge as the read
  assign cur  = (fwd_valid && fwd_addr == b_item.leaf) ? fwd_data : rd_data;
  assign full = cur >= MAX_COUNT;

  // Update and result per opcode
  always_comb begin
    item_wr = 1'b1;
    new_cnt = cur;
    res_val = cur;
    res_sat = full;
    case (b_item.op)
      OP_COUNT: begin
        new_cnt = full ? cur : cur + 1'b1;
        res_val = new_cnt;
      end
      OP_PLACE: begin
        new_cnt = full ? cur : cur + 1'b1;
      end
      OP_READ_CLEAR: begin
        new_cnt = '0;
      end
      default: begin
        item_wr = 1'b0;
        res_val = '0;
        res_sat = 1'b0;
      end
    endcase
  end

  assign wr_en   = clearing || (en && b_valid && item_wr);
  assign wr_addr = clearing ? clr_cnt[LEAF_W-1:0] : b_item.leaf;
  assign wr_data = clearing ? '0 : new_cnt;

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b_valid   <= q_pop;
      fwd_valid <= b_valid && item_wr;
      out_valid <= b_valid;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      b_item   <= q_item;
      fwd_addr <= b_item.leaf;
      fwd_data <= new_cnt;
      if (b_valid) begin
        out_leaf <= b_item.leaf;
        out_val  <= res_val;
        out_tag  <= b_item.tag;
        out_sat  <= res_sat;
      end
    end
  end

  `OLB_ASSERT_IMPL(a_no_pop_clear, clk, rst, clearing, !q_pop, "request taken during clear sweep")
  `OLB_ASSERT_IMPL(a_cnt_range, clk, rst, b_valid, cur <= MAX_COUNT, "leaf count beyond limit")
  `OLB_ASSERT_NEXT(a_none_result, clk, rst, en && b_valid && b_item.op == OP_NONE, out_valid && out_val == '0 && !out_sat, "unknown op produced a count")

endmodule

FILE: tb/octree_leaf_binning_core_tb.sv
module octree_leaf_binning_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olb_pkg::*;

  localparam int     CYCLE_LIMIT  = 4_000_000;
  localparam int     DRAIN_CYCLES = 12;
  localparam int     FEED_DEPTH   = 32;
  localparam longint FRAC_SCALE   = longint'(1) << MAX_LEVELS;
  localparam int     PHASE_ITEMS  = 190;
  localparam int     BURST_ITEMS  = 16;

  // Just above and exactly on the root midpoint of the unit box
  localparam logic [PT_W-1:0] HALF    = 32'h0000_8000;
  localparam logic [PT_W-1:0] HALF_UP = 32'h0000_8001;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [PT_W-1:0]       x;
    logic [PT_W-1:0]       y;
    logic [PT_W-1:0]       z;
    logic [LEAF_IDX_W-1:0] sel;
    logic [TAG_W-1:0]      tag;
  } point_request_t;

  typedef struct packed {
    logic [LEAF_IDX_W-1:0] leaf;
    logic [COUNT_W-1:0]    value;
    logic [TAG_W-1:0]      tag;
    logic                  sat;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [127:0]          s_tdata  = '0;
  logic [OP_W-1:0]       s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [55:0]           m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  octree_leaf_binning_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: root box, depth and per-leaf histogram
  logic signed [PT_W-1:0] box_lo [3];
  logic signed [PT_W-1:0] box_hi [3];
  logic [LVL_W-1:0]       depth_cfg;
  logic [COUNT_W-1:0]     leaf_count [NUM_LEAVES];

  point_request_t point_requests [$];
  bin_result_t    expected_bins [$];
  point_request_t live_request;

  int  issued     = 0;
  int  retired    = 0;
  int  mismatches = 0;
  int  cycles     = 0;
  int  tx_gap     = 0;
  int  rx_gap     = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  logic in_fire   = 1'b0;
  logic out_fire  = 1'b0;

  // Octant code for {gx, gy, gz}
  function automatic logic [2:0] octant_code(logic [2:0] g);
    logic [2:0] code;
    case (g)
      3'b000:  code = 3'd0;
      3'b100:  code = 3'd1;
      3'b110:  code = 3'd2;
      3'b010:  code = 3'd3;
      3'b011:  code = 3'd4;
      3'b111:  code = 3'd5;
      3'b101:  code = 3'd6;
      default: code = 3'd7;
    endcase
    return code;
  endfunction

  // Exact descent with extra fraction bits; strict compare against each midpoint
  function automatic logic [LEAF_W-1:0] locate_leaf(logic signed [PT_W-1:0] px,
                                                    logic signed [PT_W-1:0] py,
                                                    logic signed [PT_W-1:0] pz);
    longint lo [3];
    longint hi [3];
    longint pt [3];
    longint mid;
    logic [2:0] g;
    logic [LEAF_W-1:0] leaf;
    int depth;
    pt[0] = longint'(px) * FRAC_SCALE;
    pt[1] = longint'(py) * FRAC_SCALE;
    pt[2] = longint'(pz) * FRAC_SCALE;
    for (int a = 0; a < 3; a++) begin
      lo[a] = longint'(box_lo[a]) * FRAC_SCALE;
      hi[a] = longint'(box_hi[a]) * FRAC_SCALE;
    end
    depth = (depth_cfg > MAX_LEVELS) ? MAX_LEVELS : int'(depth_cfg);
    leaf = '0;
    for (int l = 0; l < depth; l++) begin
      for (int a = 0; a < 3; a++) begin
        mid = (lo[a] + hi[a]) / 2;
        g[2-a] = pt[a] > mid;
        if (g[2-a]) lo[a] = mid;
        else hi[a] = mid;
      end
      leaf = {leaf[LEAF_W-4:0], octant_code(g)};
    end
    return leaf;
  endfunction

  // Expected result of one request; updates the shadow histogram
  function automatic bin_result_t bin_point_request(point_request_t r);
    bin_result_t e;
    logic [LEAF_W-1:0] idx;
    logic [COUNT_W-1:0] c;
    e = '0;
    e.tag = r.tag;
    case (r.op)
      OP_COUNT, OP_PLACE: begin
        idx = locate_leaf(r.x, r.y, r.z);
        c = leaf_count[idx];
        e.sat = (c >= MAX_COUNT);
        if (!e.sat) leaf_count[idx] = c + 1'b1;
        e.leaf = idx;
        e.value = (r.op == OP_COUNT) ? leaf_count[idx] : c;
      end
      OP_READ_CLEAR: begin
        idx = r.sel[LEAF_W-1:0];
        c = leaf_count[idx];
        leaf_count[idx] = '0;
        e.leaf = idx;
        e.value = c;
        e.sat = (c >= MAX_COUNT);
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  // Gap after a handshake: mostly none, some short, a few long
  function automatic int pick_gap(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Coordinate mostly inside the box, some on its edges or midpoint, rest anywhere
  function automatic logic [PT_W-1:0] pick_coord(int a);
    longint lo, hi, tmp, mid;
    logic [63:0] rnd;
    logic [PT_W-1:0] v;
    int r;
    lo = box_lo[a];
    hi = box_hi[a];
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    mid = (lo + hi) / 2;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      rnd = {$urandom, $urandom} % 64'(hi - lo + 1);
      v = 32'(lo + longint'(rnd));
    end else if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       v = 32'(lo);
        1:       v = 32'(hi);
        2:       v = 32'(mid);
        default: v = 32'(mid + 1);
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic point_request_t make_request(logic [OP_W-1:0] op, logic [PT_W-1:0] x,
                                                  logic [PT_W-1:0] y, logic [PT_W-1:0] z,
                                                  logic [LEAF_IDX_W-1:0] sel,
                                                  logic [TAG_W-1:0] tag);
    point_request_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.z = z;
    r.sel = sel;
    r.tag = tag;
    return r;
  endfunction

  function automatic point_request_t random_request(int leaf_span);
    point_request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.op = OP_COUNT;
    else if (pick < 75) r.op = OP_PLACE;
    else if (pick < 95) r.op = OP_READ_CLEAR;
    else r.op = OP_NONE;
    r.x = pick_coord(0);
    r.y = pick_coord(1);
    r.z = pick_coord(2);
    // reads mostly aim at leaves the current depth can reach
    if ($urandom_range(0, 3) == 0) r.sel = LEAF_IDX_W'($urandom);
    else r.sel = LEAF_IDX_W'($urandom_range(0, leaf_span - 1));
    r.tag = TAG_W'($urandom);
    return r;
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_fire) begin
      // hold until accepted
    end else if (tx_gap > 0) begin
      tx_gap = tx_gap - 1;
      s_tvalid <= 1'b0;
    end else if (point_requests.size() != 0) begin
      live_request = point_requests.pop_front();
      s_tdata <= {live_request.tag, live_request.sel, live_request.z, live_request.y,
                  live_request.x};
      s_tuser <= live_request.op;
      s_tvalid <= 1'b1;
      tx_gap = pick_gap(tx_idle_on);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      m_tready <= 1'b0;
    end else begin
      if (out_fire || $urandom_range(0, 15) == 0) rx_gap = pick_gap(rx_idle_on);
      m_tready <= (rx_gap == 0);
    end
  end

  // Result checker and request predictor
  always @(posedge clk) begin : monitor
    bin_result_t got;
    bin_result_t want;
    in_fire  <= !rst && s_tvalid && s_tready;
    out_fire <= !rst && m_tvalid && m_tready;
    if (!rst && m_tvalid && m_tready) begin
      got.leaf  = m_tdata[11:0];
      got.value = m_tdata[32:12];
      got.tag   = m_tdata[52:33];
      got.sat   = m_tdata[53];
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: leaf %0d count %0d tag %0h sat %0b",
                   got.leaf, got.value, got.tag, got.sat);
      end else begin
        want = expected_bins.pop_front();
        retired++;
        if (got.leaf !== want.leaf || got.value !== want.value ||
            got.tag !== want.tag || got.sat !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected leaf %0d count %0d tag %0h sat %0b, ",
                      "got leaf %0d count %0d tag %0h sat %0b"},
                     want.leaf, want.value, want.tag, want.sat,
                     got.leaf, got.value, got.tag, got.sat);
        end
      end
    end
    if (!rst && s_tvalid && s_tready) expected_bins.push_back(bin_point_request(live_request));
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("octree_leaf_binning_core_tb failed");
      $finish;
    end
  end

  task automatic send_request(point_request_t r);
    while (point_requests.size() >= FEED_DEPTH) @(posedge clk);
    point_requests.push_back(r);
    issued++;
  endtask

  // Wait until every request has its result back, then let the pipe settle
  task automatic wait_drained;
    do @(negedge clk); while (issued != retired);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MIN_X:  box_lo[0] = val;
      CFG_MAX_X:  box_hi[0] = val;
      CFG_MIN_Y:  box_lo[1] = val;
      CFG_MAX_Y:  box_hi[1] = val;
      CFG_MIN_Z:  box_lo[2] = val;
      CFG_MAX_Z:  box_hi[2] = val;
      CFG_LEVELS: depth_cfg = val[LVL_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic feed_random(int n);
    int span;
    span = 1 << (3 * ((depth_cfg > MAX_LEVELS) ? MAX_LEVELS : int'(depth_cfg)));
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < n; k++) send_request(random_request(span));
  endtask

  // New box and depth once idle, then a burst of random requests
  task automatic run_phase(logic [PT_W-1:0] lx, logic [PT_W-1:0] hx,
                           logic [PT_W-1:0] ly, logic [PT_W-1:0] hy,
                           logic [PT_W-1:0] lz, logic [PT_W-1:0] hz,
                           logic [LVL_W-1:0] lvl);
    wait_drained;
    write_reg(CFG_MIN_X, lx);
    write_reg(CFG_MAX_X, hx);
    write_reg(CFG_MIN_Y, ly);
    write_reg(CFG_MAX_Y, hy);
    write_reg(CFG_MIN_Z, lz);
    write_reg(CFG_MAX_Z, hz);
    write_reg(CFG_LEVELS, CFG_DATA_W'(lvl));
    @(posedge clk);
    feed_random(PHASE_ITEMS);
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 32'sd0;
      box_hi[a] = 32'sd65536;
    end
    depth_cfg = 3'd1;
    foreach (leaf_count[i]) leaf_count[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unit box, one level: midpoint tie, every octant, field extremes
    send_request(make_request(OP_COUNT, 32'h0, 32'h0, 32'h0, 12'h0, 20'h0));
    send_request(make_request(OP_COUNT, HALF, HALF, HALF, 12'h0, 20'h1));
    send_request(make_request(OP_COUNT, HALF_UP, 32'h0, 32'h0, 12'h0, 20'h2));
    send_request(make_request(OP_PLACE, HALF_UP, HALF_UP, 32'h0, 12'h0, 20'h3));
    send_request(make_request(OP_COUNT, 32'h0, HALF_UP, 32'h0, 12'h0, 20'h4));
    send_request(make_request(OP_COUNT, 32'h0, HALF_UP, HALF_UP, 12'h0, 20'h5));
    send_request(make_request(OP_PLACE, HALF_UP, HALF_UP, HALF_UP, 12'h0, 20'h6));
    send_request(make_request(OP_COUNT, HALF_UP, 32'h0, HALF_UP, 12'h0, 20'h7));
    send_request(make_request(OP_COUNT, 32'h0, 32'h0, HALF_UP, 12'h0, 20'h8));
    send_request(make_request(OP_COUNT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              12'hFFF, 20'hFFFFF));
    send_request(make_request(OP_PLACE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              12'h0, 20'hA5A5A));
    send_request(make_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              12'hFFF, 20'hFFFFF));
    send_request(make_request(OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, 12'hFFF, 20'h5A5A5));
    for (int i = 0; i < 8; i++)
      send_request(make_request(OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, LEAF_IDX_W'(i),
                                TAG_W'(i)));
    send_request(make_request(OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, 12'h0, 20'h0));
    feed_random(PHASE_ITEMS);

    // Full depth on a wide symmetric box
    run_phase(-32'sd6553600, 32'sd6553600, -32'sd6553600, 32'sd6553600,
              -32'sd6553600, 32'sd6553600, 3'd4);
    // Inverted x and z
    run_phase(32'sd327680, -32'sd327680, -32'sd327680, 32'sd327680,
              32'sd327680, -32'sd327680, 3'd2);
    // Zero levels: every count and place lands in leaf 0
    run_phase(32'sd0, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 32'sd65536, 3'd0);
    // Depth beyond the maximum on the widest box
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 3'd7);
    // Degenerate box
    run_phase(32'sd12345, 32'sd12345, 32'sd12345, 32'sd12345, 32'sd12345, 32'sd12345, 3'd3);
    run_phase($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 3'd5);
    // Widest box turned inside out
    run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 3'd1);
    // Tiny box: the midpoints lean on the extra fraction bits
    run_phase(32'sd0, 32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd3, 3'd6);

    // Back-to-back hits on leaf 0, then count, place and read it back
    wait_drained;
    write_reg(CFG_LEVELS, CFG_DATA_W'(0));
    @(posedge clk);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_request(make_request(OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, 12'h0, 20'h0));
    for (int n = 0; n < BURST_ITEMS; n++)
      send_request(make_request(OP_COUNT, $urandom, $urandom, $urandom, LEAF_IDX_W'($urandom),
                                TAG_W'($urandom)));
    send_request(make_request(OP_PLACE, $urandom, $urandom, $urandom, 12'h0, 20'h11111));
    send_request(make_request(OP_COUNT, $urandom, $urandom, $urandom, 12'h0, 20'h22222));
    send_request(make_request(OP_PLACE, $urandom, $urandom, $urandom, 12'h0, 20'h33333));
    send_request(make_request(OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, 12'h0, 20'h44444));
    send_request(make_request(OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, 12'h0, 20'h55555));

    wait_drained;
    if (mismatches == 0) begin
      $display("octree_leaf_binning_core_tb passed");
    end else begin
      $display("octree_leaf_binning_core_tb failed");
    end
    $finish;
  end

endmodule
